FILE: rtl/sqidx_pkg.sv
// ----------------------------------------------------------------------------
// sqidx_pkg
// shared constants, types and square root step functions for the symmetric
// quad index decoder
// ----------------------------------------------------------------------------
package sqidx_pkg;

   // orbital index width and derived quad index width
   localparam int INDEX_BITS   = 10;
   localparam int QUAD_BITS    = 4 * INDEX_BITS - 2;
   localparam int QUAD_INDEX_W = 38;
   localparam int PERM_BITS    = 3;

   // square root steps retired per pipeline stage
   localparam int STEPS_PER_STAGE = 3;

   // quad split: root of 8x+1 needs 2*INDEX_BITS+1 bits
   localparam int QUAD_STAGES = (2 * INDEX_BITS + 1 + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int QROOT_W     = QUAD_STAGES * STEPS_PER_STAGE;
   localparam int QN_W        = 2 * QROOT_W;
   localparam int TRI_W       = QROOT_W - 1;

   // pair split: root of 8p+1 needs INDEX_BITS+2 bits
   localparam int PAIR_STAGES = (INDEX_BITS + 2 + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int PROOT_W     = PAIR_STAGES * STEPS_PER_STAGE;
   localparam int PN_W        = 2 * PROOT_W;

   // stream widths
   localparam int REQ_TDATA_W = ((QUAD_INDEX_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = 4 * INDEX_BITS + PERM_BITS;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int PERM_LSB    = 4 * INDEX_BITS;

   // permutation codes
   localparam logic [PERM_BITS-1:0] PERM_IJKL = 3'd0;
   localparam logic [PERM_BITS-1:0] PERM_JILK = 3'd1;
   localparam logic [PERM_BITS-1:0] PERM_KLIJ = 3'd2;
   localparam logic [PERM_BITS-1:0] PERM_LKJI = 3'd3;
   localparam logic [PERM_BITS-1:0] PERM_ILKJ = 3'd4;
   localparam logic [PERM_BITS-1:0] PERM_LIJK = 3'd5;
   localparam logic [PERM_BITS-1:0] PERM_KJIL = 3'd6;
   localparam logic [PERM_BITS-1:0] PERM_JKLI = 3'd7;

   typedef struct packed {
      logic [QROOT_W:0]   rem;
      logic [QROOT_W-1:0] root;
   } sqrt_acc_type;

   typedef struct packed {
      logic [TRI_W-1:0] low;
      logic [TRI_W-1:0] high;
   } tri_pair_type;

   // one restoring square root step on two more bits of the radicand
   function automatic sqrt_acc_type sqrt_step(sqrt_acc_type acc, logic [1:0] nbits);
      logic [QROOT_W+2:0] rem_shift;
      logic [QROOT_W+2:0] trial;
      sqrt_acc_type       res;
      rem_shift = {acc.rem, nbits};
      trial     = {1'b0, acc.root, 2'b01};
      if (rem_shift >= trial) begin
         res.rem  = (QROOT_W + 1)'(rem_shift - trial);
         res.root = {acc.root[QROOT_W-2:0], 1'b1};
      end else begin
         res.rem  = rem_shift[QROOT_W:0];
         res.root = {acc.root[QROOT_W-2:0], 1'b0};
      end
      return res;
   endfunction

   // s = isqrt(8x+1), r = 8x+1-s*s; high = (s-1)/2, low = x - high(high+1)/2
   function automatic tri_pair_type tri_finish(sqrt_acc_type acc);
      logic [QROOT_W-1:0] root_m1;
      logic [QROOT_W+1:0] adj;
      tri_pair_type       res;
      root_m1  = acc.root - QROOT_W'(1);
      adj      = (QROOT_W + 2)'(acc.rem) + (QROOT_W + 2)'({acc.root, 1'b0})
                 - (QROOT_W + 2)'(1);
      res.high = root_m1[QROOT_W-1:1];
      if (acc.root[0]) begin
         res.low = TRI_W'(acc.rem[QROOT_W:3]);
      end else begin
         res.low = adj[QROOT_W+1:3];
      end
      return res;
   endfunction

endpackage

FILE: rtl/sqidx_quad_split.sv
// ----------------------------------------------------------------------------
// sqidx_quad_split
// pipelined triangular inverse of the quad index into low and high pair
// indices, three root bits per stage plus a finishing stage
// ----------------------------------------------------------------------------
module sqidx_quad_split
   import sqidx_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic [QUAD_INDEX_W-1:0] quad_index,
   output logic                    out_valid,
   output tri_pair_type            out_pair
);

   logic [QUAD_BITS-1:0]   x_value;
   logic [QN_W-1:0]        n_first;
   sqrt_acc_type           acc_in  [QUAD_STAGES];
   sqrt_acc_type           acc_ff  [QUAD_STAGES];
   logic [QN_W-1:0]        n_ff    [QUAD_STAGES-1];
   logic [QUAD_STAGES-1:0] valid_ff;
   logic                   done_valid_ff;
   tri_pair_type           pair_ff;

   assign x_value = QUAD_BITS'(quad_index);
   assign n_first = QN_W'({x_value, 3'b001});

   always_comb begin
      acc_in[0] = '0;
      for (int t = 0; t < STEPS_PER_STAGE; t++) begin
         acc_in[0] = sqrt_step(acc_in[0], n_first[QN_W-1-2*t -: 2]);
      end
      for (int k = 1; k < QUAD_STAGES; k++) begin
         acc_in[k] = acc_ff[k-1];
         for (int t = 0; t < STEPS_PER_STAGE; t++) begin
            acc_in[k] = sqrt_step(acc_in[k],
                                  n_ff[k-1][QN_W-1-2*(k*STEPS_PER_STAGE+t) -: 2]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         done_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff      <= {valid_ff[QUAD_STAGES-2:0], in_valid};
         done_valid_ff <= valid_ff[QUAD_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < QUAD_STAGES; k++) begin
            acc_ff[k] <= acc_in[k];
         end
         n_ff[0] <= n_first;
         for (int k = 1; k < QUAD_STAGES - 1; k++) begin
            n_ff[k] <= n_ff[k-1];
         end
         pair_ff <= tri_finish(acc_ff[QUAD_STAGES-1]);
      end
   end

   assign out_valid = done_valid_ff;
   assign out_pair  = pair_ff;

endmodule

FILE: rtl/sqidx_pair_split.sv
// ----------------------------------------------------------------------------
// sqidx_pair_split
// pipelined triangular inverse of one pair index into two orbital indices
// ----------------------------------------------------------------------------
module sqidx_pair_split
   import sqidx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [TRI_W-1:0]      pair_value,
   output logic                  out_valid,
   output logic [INDEX_BITS-1:0] low_index,
   output logic [INDEX_BITS-1:0] high_index
);

   logic [PN_W-1:0]        n_first;
   sqrt_acc_type           acc_in  [PAIR_STAGES];
   sqrt_acc_type           acc_ff  [PAIR_STAGES];
   logic [PN_W-1:0]        n_ff    [PAIR_STAGES-1];
   logic [PAIR_STAGES-1:0] valid_ff;
   logic                   done_valid_ff;
   tri_pair_type           leaf_in;
   logic [INDEX_BITS-1:0]  low_ff;
   logic [INDEX_BITS-1:0]  high_ff;

   assign n_first = PN_W'({pair_value, 3'b001});

   always_comb begin
      acc_in[0] = '0;
      for (int t = 0; t < STEPS_PER_STAGE; t++) begin
         acc_in[0] = sqrt_step(acc_in[0], n_first[PN_W-1-2*t -: 2]);
      end
      for (int k = 1; k < PAIR_STAGES; k++) begin
         acc_in[k] = acc_ff[k-1];
         for (int t = 0; t < STEPS_PER_STAGE; t++) begin
            acc_in[k] = sqrt_step(acc_in[k],
                                  n_ff[k-1][PN_W-1-2*(k*STEPS_PER_STAGE+t) -: 2]);
         end
      end
   end

   assign leaf_in = tri_finish(acc_ff[PAIR_STAGES-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         done_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff      <= {valid_ff[PAIR_STAGES-2:0], in_valid};
         done_valid_ff <= valid_ff[PAIR_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < PAIR_STAGES; k++) begin
            acc_ff[k] <= acc_in[k];
         end
         n_ff[0] <= n_first;
         for (int k = 1; k < PAIR_STAGES - 1; k++) begin
            n_ff[k] <= n_ff[k-1];
         end
         low_ff  <= leaf_in.low[INDEX_BITS-1:0];
         high_ff <= leaf_in.high[INDEX_BITS-1:0];
      end
   end

   assign out_valid  = done_valid_ff;
   assign low_index  = low_ff;
   assign high_index = high_ff;

endmodule

FILE: rtl/sqidx_perm_serializer.sv
// ----------------------------------------------------------------------------
// sqidx_perm_serializer
// holds one decoded quadruple and emits its eight symmetric permutations,
// one per accepted item; drives the pipeline advance
// ----------------------------------------------------------------------------
module sqidx_perm_serializer
   import sqidx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [INDEX_BITS-1:0] index_i,
   input  logic [INDEX_BITS-1:0] index_j,
   input  logic [INDEX_BITS-1:0] index_k,
   input  logic [INDEX_BITS-1:0] index_l,
   output logic                  advance,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [INDEX_BITS-1:0] first_index,
   output logic [INDEX_BITS-1:0] second_index,
   output logic [INDEX_BITS-1:0] third_index,
   output logic [INDEX_BITS-1:0] fourth_index,
   output logic [PERM_BITS-1:0]  perm_number,
   output logic                  last
);

   logic                  busy_ff;
   logic [PERM_BITS-1:0]  perm_ff;
   logic [INDEX_BITS-1:0] i_ff;
   logic [INDEX_BITS-1:0] j_ff;
   logic [INDEX_BITS-1:0] k_ff;
   logic [INDEX_BITS-1:0] l_ff;

   assign advance = !busy_ff || (out_ready && (perm_ff == PERM_JKLI));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         perm_ff <= PERM_IJKL;
      end else if (advance) begin
         busy_ff <= in_valid;
         perm_ff <= PERM_IJKL;
      end else if (out_ready) begin
         perm_ff <= perm_ff + PERM_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         i_ff <= index_i;
         j_ff <= index_j;
         k_ff <= index_k;
         l_ff <= index_l;
      end
   end

   always_comb begin
      case (perm_ff)
         PERM_IJKL: {first_index, second_index, third_index, fourth_index} =
                       {i_ff, j_ff, k_ff, l_ff};
         PERM_JILK: {first_index, second_index, third_index, fourth_index} =
                       {j_ff, i_ff, l_ff, k_ff};
         PERM_KLIJ: {first_index, second_index, third_index, fourth_index} =
                       {k_ff, l_ff, i_ff, j_ff};
         PERM_LKJI: {first_index, second_index, third_index, fourth_index} =
                       {l_ff, k_ff, j_ff, i_ff};
         PERM_ILKJ: {first_index, second_index, third_index, fourth_index} =
                       {i_ff, l_ff, k_ff, j_ff};
         PERM_LIJK: {first_index, second_index, third_index, fourth_index} =
                       {l_ff, i_ff, j_ff, k_ff};
         PERM_KJIL: {first_index, second_index, third_index, fourth_index} =
                       {k_ff, j_ff, i_ff, l_ff};
         PERM_JKLI: {first_index, second_index, third_index, fourth_index} =
                       {j_ff, k_ff, l_ff, i_ff};
         default:   {first_index, second_index, third_index, fourth_index} =
                       {i_ff, j_ff, k_ff, l_ff};
      endcase
   end

   assign out_valid   = busy_ff;
   assign perm_number = perm_ff;
   assign last        = (perm_ff == PERM_JKLI);

endmodule

FILE: rtl/symmetric_quad_index_decode_unit.sv
// ----------------------------------------------------------------------------
// symmetric_quad_index_decode_unit
// decodes a packed quad index into its orbital quadruple and streams the
// eight symmetric permutations
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  tdata: quad_index
//   rsp_     out  rsp_tvalid/rsp_tready  tdata: indices, perm_number; tlast
//
// one item in gives eight items out, one per cycle while rsp_tready is high, so
// the single result channel sets the sustained rate; req_ takes a new item only
// when the last permutation is taken or the output is empty; a result passes
// 7 + 1 quad root stages, 4 + 1 pair root stages, then the permutation register
// reset clears the valid bits and the permutation counter only; no clearing pass
// a stall on rsp_ freezes the whole pipeline; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module symmetric_quad_index_decode_unit
   import sqidx_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // quad_index
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // first, second, third, fourth, perm_number
   output logic                   rsp_tlast
);

   logic                  advance;
   logic                  quad_valid;
   tri_pair_type          quad_pair;
   logic                  lo_valid;
   logic                  hi_valid;
   logic [INDEX_BITS-1:0] index_i;
   logic [INDEX_BITS-1:0] index_j;
   logic [INDEX_BITS-1:0] index_k;
   logic [INDEX_BITS-1:0] index_l;
   logic [INDEX_BITS-1:0] first_index;
   logic [INDEX_BITS-1:0] second_index;
   logic [INDEX_BITS-1:0] third_index;
   logic [INDEX_BITS-1:0] fourth_index;
   logic [PERM_BITS-1:0]  perm_number;

   assign req_tready = advance;

   sqidx_quad_split u_quad_split (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_tvalid),
      .quad_index (req_tdata[QUAD_INDEX_W-1:0]),
      .out_valid  (quad_valid),
      .out_pair   (quad_pair)
   );

   // low pair gives (i, k)
   sqidx_pair_split u_pair_lo (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (quad_valid),
      .pair_value (quad_pair.low),
      .out_valid  (lo_valid),
      .low_index  (index_i),
      .high_index (index_k)
   );

   // high pair gives (j, l)
   sqidx_pair_split u_pair_hi (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (quad_valid),
      .pair_value (quad_pair.high),
      .out_valid  (hi_valid),
      .low_index  (index_j),
      .high_index (index_l)
   );

   sqidx_perm_serializer u_serializer (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (lo_valid && hi_valid),
      .index_i      (index_i),
      .index_j      (index_j),
      .index_k      (index_k),
      .index_l      (index_l),
      .advance      (advance),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .first_index  (first_index),
      .second_index (second_index),
      .third_index  (third_index),
      .fourth_index (fourth_index),
      .perm_number  (perm_number),
      .last         (rsp_tlast)
   );

   assign rsp_tdata = RSP_TDATA_W'({perm_number, fourth_index, third_index,
                                    second_index, first_index});

   a_run_starts_at_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=>
         (!rsp_tvalid || (rsp_tdata[PERM_LSB +: PERM_BITS] == PERM_IJKL)))
      else $error("run does not restart at the first permutation");

   a_perm_steps : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (rsp_tvalid && (rsp_tdata[PERM_LSB +: PERM_BITS] ==
            PERM_BITS'($past(rsp_tdata[PERM_LSB +: PERM_BITS]) + PERM_BITS'(1)))))
      else $error("permutation run broken");

   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   a_lanes_aligned : assert property (@(posedge clock) disable iff (reset)
      lo_valid == hi_valid)
      else $error("pair split lanes out of step");

endmodule

FILE: tb/symmetric_quad_index_decode_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// symmetric_quad_index_decode_unit_test
// drives packed quad indices into the decoder and checks all eight symmetric
// permutations of each decoded quadruple, in order, against hand-read values
// or a local decoder; a directed table comes first, then random indices in
// bursts while the result side stalls on its own pattern
// ----------------------------------------------------------------------------
module symmetric_quad_index_decode_unit_test;
   import sqidx_pkg::*;

   localparam logic [QUAD_INDEX_W-1:0] QUAD_HIGH = 38'd137707782399;
   localparam int N_DIRECTED   = 14;
   localparam int RANDOM_ITEMS = 100;
   localparam int DRAIN_CYCLES = 24;
   localparam int IDLE_LIMIT   = 2000;

   typedef logic [INDEX_BITS-1:0] orb_type;

   typedef struct packed {
      orb_type i;
      orb_type j;
      orb_type k;
      orb_type l;
   } quadruple_type;

   typedef struct packed {
      orb_type              first_idx;
      orb_type              second_idx;
      orb_type              third_idx;
      orb_type              fourth_idx;
      logic [PERM_BITS-1:0] perm;
      logic                 last;
   } perm_item_type;

   typedef struct packed {
      logic [QUAD_INDEX_W-1:0] quad;
      logic                    known;
      quadruple_type           orbs;
   } directed_row_type;

   // quad index, known flag, then i j k l where read off by hand
   localparam directed_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      {38'd0,            1'b1, 10'd0,    10'd0,    10'd0,    10'd0},
      {38'd1,            1'b1, 10'd0,    10'd0,    10'd0,    10'd1},
      {38'd2,            1'b1, 10'd0,    10'd0,    10'd1,    10'd1},
      {38'd230,          1'b1, 10'd5,    10'd5,    10'd5,    10'd5},
      {38'd137707782399, 1'b1, 10'd1023, 10'd1023, 10'd1023, 10'd1023},
      {38'd137707257600, 1'b1, 10'd0,    10'd1023, 10'd0,    10'd1023},
      {38'd3,            1'b0, 40'd0},
      {38'd999999,       1'b0, 40'd0},
      {38'd137707257599, 1'b0, 40'd0},
      {38'd137707782400, 1'b0, 40'd0},
      {38'h3F_FFFF_FFFF, 1'b0, 40'd0},
      {38'h20_0000_0000, 1'b0, 40'd0},
      {38'h2A_AAAA_AAAA, 1'b0, 40'd0},
      {38'h15_5555_5555, 1'b0, 40'd0}
   };

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   perm_item_type pending_perms[$];
   int            failures    = 0;
   int            idle_cycles = 0;
   int            burst_left  = 0;

   symmetric_quad_index_decode_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] tri_num(logic [63:0] x);
      return (x * (x + 64'd1)) >> 1;
   endfunction

   // largest q with tri_num(q) <= x
   function automatic logic [63:0] tri_root(logic [63:0] x);
      logic [63:0] q;
      logic [63:0] t;
      q = '0;
      for (int b = 31; b >= 0; b--) begin
         t = q | (64'd1 << b);
         if (tri_num(t) <= x) q = t;
      end
      return q;
   endfunction

   function automatic quadruple_type decode_quadruple(logic [QUAD_INDEX_W-1:0] quad);
      logic [63:0]   x;
      logic [63:0]   pair_lo;
      logic [63:0]   pair_hi;
      logic [63:0]   k_full;
      logic [63:0]   l_full;
      quadruple_type orbs;
      x       = 64'(quad) & ((64'd1 << QUAD_BITS) - 64'd1);
      pair_hi = tri_root(x);
      pair_lo = x - tri_num(pair_hi);
      k_full  = tri_root(pair_lo);
      l_full  = tri_root(pair_hi);
      orbs.i  = orb_type'(pair_lo - tri_num(k_full));
      orbs.k  = orb_type'(k_full);
      orbs.j  = orb_type'(pair_hi - tri_num(l_full));
      orbs.l  = orb_type'(l_full);
      return orbs;
   endfunction

   function automatic void push_perms(quadruple_type o);
      perm_item_type item;
      for (int n = 0; n < (1 << PERM_BITS); n++) begin
         item.perm = PERM_BITS'(n);
         case (item.perm)
            PERM_IJKL: {item.first_idx, item.second_idx, item.third_idx, item.fourth_idx}
                          = {o.i, o.j, o.k, o.l};
            PERM_JILK: {item.first_idx, item.second_idx, item.third_idx, item.fourth_idx}
                          = {o.j, o.i, o.l, o.k};
            PERM_KLIJ: {item.first_idx, item.second_idx, item.third_idx, item.fourth_idx}
                          = {o.k, o.l, o.i, o.j};
            PERM_LKJI: {item.first_idx, item.second_idx, item.third_idx, item.fourth_idx}
                          = {o.l, o.k, o.j, o.i};
            PERM_ILKJ: {item.first_idx, item.second_idx, item.third_idx, item.fourth_idx}
                          = {o.i, o.l, o.k, o.j};
            PERM_LIJK: {item.first_idx, item.second_idx, item.third_idx, item.fourth_idx}
                          = {o.l, o.i, o.j, o.k};
            PERM_KJIL: {item.first_idx, item.second_idx, item.third_idx, item.fourth_idx}
                          = {o.k, o.j, o.i, o.l};
            PERM_JKLI: {item.first_idx, item.second_idx, item.third_idx, item.fourth_idx}
                          = {o.j, o.k, o.l, o.i};
            default:   {item.first_idx, item.second_idx, item.third_idx, item.fourth_idx}
                          = {o.i, o.j, o.k, o.l};
         endcase
         item.last = (item.perm == PERM_JKLI);
         pending_perms.push_back(item);
      end
   endfunction

   // returns at the edge where the item is taken
   task automatic offer_quad(input logic [QUAD_INDEX_W-1:0] quad);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(quad);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   initial begin : stimulus
      logic [QUAD_INDEX_W-1:0] quad;
      logic [63:0]             a;
      logic [63:0]             b;
      logic [63:0]             c;
      logic [63:0]             d;
      logic [63:0]             lo_pair;
      logic [63:0]             hi_pair;
      logic [63:0]             draw;
      int                      span;
      int                      mode;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_DIRECTED; r++) begin
         offer_quad(DIRECTED_ROWS[r].quad);
         push_perms(DIRECTED_ROWS[r].known ? DIRECTED_ROWS[r].orbs
                                           : decode_quadruple(DIRECTED_ROWS[r].quad));
         @(negedge clock);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         mode = $urandom_range(0, 19);
         draw = {$urandom(), $urandom()};
         if (mode < 9) begin
            // well-formed index packed from four orbitals, mostly small ones
            span = ($urandom_range(0, 2) == 0) ? (1 << INDEX_BITS) - 1 : 15;
            a = $urandom_range(0, span);
            b = $urandom_range(0, span);
            c = $urandom_range(0, span);
            d = $urandom_range(0, span);
            lo_pair = (a <= c) ? tri_num(c) + a : tri_num(a) + c;
            hi_pair = (b <= d) ? tri_num(d) + b : tri_num(b) + d;
            if (lo_pair > hi_pair) {lo_pair, hi_pair} = {hi_pair, lo_pair};
            quad = QUAD_INDEX_W'(tri_num(hi_pair) + lo_pair);
         end else if (mode < 14) begin
            quad = QUAD_INDEX_W'(draw % (64'(QUAD_HIGH) + 64'd1));
         end else if (mode < 17) begin
            quad = QUAD_INDEX_W'($urandom_range(0, 4095));
         end else begin
            quad = QUAD_INDEX_W'(draw);
         end
         offer_quad(quad);
         push_perms(decode_quadruple(quad));
         @(negedge clock);
      end
      req_tvalid <= 1'b0;

      while (pending_perms.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("symmetric_quad_index_decode_unit_test: done, clean");
      end else begin
         $display("symmetric_quad_index_decode_unit_test: done, errors");
      end
      $finish;
   end

   initial begin : result_stalls
      logic [15:0] pattern;
      int          pos;
      pattern = '1;
      pos     = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (pos == 0) begin
            case ($urandom_range(0, 3))
               0:       pattern = '1;
               1:       pattern = 16'($urandom()) & 16'($urandom());
               default: pattern = 16'($urandom());
            endcase
            pos = 16;
         end
         pos--;
         rsp_tready <= pattern[pos];
      end
   end

   always @(posedge clock) begin : check_perms
      perm_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_perms.size() == 0) begin
            failures++;
            $display("%0t: unexpected item, expected none, got tdata %h tlast %b",
                     $time, rsp_tdata, rsp_tlast);
         end else begin
            want = pending_perms.pop_front();
            check_field("first_index", 16'(want.first_idx),
                        16'(rsp_tdata[0 +: INDEX_BITS]));
            check_field("second_index", 16'(want.second_idx),
                        16'(rsp_tdata[INDEX_BITS +: INDEX_BITS]));
            check_field("third_index", 16'(want.third_idx),
                        16'(rsp_tdata[2 * INDEX_BITS +: INDEX_BITS]));
            check_field("fourth_index", 16'(want.fourth_idx),
                        16'(rsp_tdata[3 * INDEX_BITS +: INDEX_BITS]));
            check_field("perm_number", 16'(want.perm),
                        16'(rsp_tdata[PERM_LSB +: PERM_BITS]));
            check_field("tdata padding", 16'(0),
                        16'(rsp_tdata[RSP_TDATA_W-1:RSP_FIELD_W]));
            check_field("last", 16'(want.last), 16'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      do @(posedge clock); while (idle_cycles < IDLE_LIMIT);
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("symmetric_quad_index_decode_unit_test: done, errors");
      $finish;
   end

endmodule

FILE: sim.f
rtl/sqidx_pkg.sv
rtl/sqidx_quad_split.sv
rtl/sqidx_pair_split.sv
rtl/sqidx_perm_serializer.sv
rtl/symmetric_quad_index_decode_unit.sv
tb/symmetric_quad_index_decode_unit_test.sv
